/* design/cqd_pkg.sv */
// ----------------------------------------------------------------------------
// cqd_pkg: shared definitions for the circular queue with dump
// Command and status codes, default depth, and the control/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package cqd_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int DATA_W        = 32;

    // Command codes carried on the input channel
    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_DEQ  = 2'd1;
    localparam logic [1:0] CMD_DISP = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       wr_en;        // write push value at tail, bump tail and count
        logic       walk_start;   // load walk pointer from head, issue read at head
        logic       walk_one;     // walk covers one entry (dequeue) instead of all
        logic       walk_step;    // current walk entry consumed, move to next slot
        logic       pop;          // advance head and drop count
        logic       out_load;     // load the output payload registers
        logic [1:0] out_status;
        logic       out_from_mem; // data from memory read port, else zero
        logic       out_last;
    } dp_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic walk_last;          // the pending walk entry is the final one
    } dp_status_t;

endpackage

/* design/cqd_ctrl.sv */
// ----------------------------------------------------------------------------
// cqd_ctrl: command sequencer for the circular queue
// Decodes accepted commands, sequences the dequeue/display walk, and owns
// the handshake flags of both channels.
// ----------------------------------------------------------------------------
module cqd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  cqd_pkg::dp_status_t  stat,
    output cqd_pkg::dp_ctrl_t    ctl
);
    import cqd_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic state_reg, state_next;
    logic pop_mode_reg, pop_mode_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;
    logic accept;

    // Output register can take a new beat when empty or being drained
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = aresetn && (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // Command decode and walk sequencing
    always_comb begin
        state_next    = state_reg;
        pop_mode_next = pop_mode_reg;
        ctl           = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_cmd)
                        CMD_ENQ: begin
                            ctl.out_load = 1'b1;
                            ctl.out_last = 1'b1;
                            if (stat.full) begin
                                ctl.out_status = ST_OVERFLOW;
                            end else begin
                                ctl.wr_en      = 1'b1;
                                ctl.out_status = ST_OK;
                            end
                        end
                        CMD_DEQ: begin
                            if (stat.empty) begin
                                ctl.out_load   = 1'b1;
                                ctl.out_last   = 1'b1;
                                ctl.out_status = ST_UNDERFLOW;
                            end else begin
                                ctl.walk_start = 1'b1;
                                ctl.walk_one   = 1'b1;
                                pop_mode_next  = 1'b1;
                                state_next     = S_WALK;
                            end
                        end
                        CMD_DISP: begin
                            if (stat.empty) begin
                                ctl.out_load   = 1'b1;
                                ctl.out_last   = 1'b1;
                                ctl.out_status = ST_EMPTY;
                            end else begin
                                ctl.walk_start = 1'b1;
                                pop_mode_next  = 1'b0;
                                state_next     = S_WALK;
                            end
                        end
                        default: begin
                            // unused code: dropped without a result
                        end
                    endcase
                end
            end
            S_WALK: begin
                // read data for the walk pointer is ready; emit when output frees
                if (out_free) begin
                    ctl.out_load     = 1'b1;
                    ctl.out_status   = ST_OK;
                    ctl.out_from_mem = 1'b1;
                    ctl.out_last     = stat.walk_last;
                    ctl.walk_step    = 1'b1;
                    ctl.pop          = pop_mode_reg;
                    if (stat.walk_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        if (ctl.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pop_mode_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pop_mode_reg <= pop_mode_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // A waiting beat is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !ctl.out_load)
        else $error("cqd_ctrl: output beat overwritten while stalled");

    // An accepted enqueue always yields a beat in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_cmd == CMD_ENQ) |=> m_valid_reg)
        else $error("cqd_ctrl: enqueue produced no result");

    // The final walk entry returns the sequencer to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK && out_free && stat.walk_last) |=> state_reg == S_IDLE)
        else $error("cqd_ctrl: walk did not finish after last entry");

endmodule

/* design/cqd_dpath.sv */
// ----------------------------------------------------------------------------
// cqd_dpath: storage and pointers of the circular queue
// Entry memory with registered read port, head/tail/count registers, the
// walk pointer and remaining count, and the output payload registers.
// ----------------------------------------------------------------------------
module cqd_dpath #(
    parameter int DEPTH = cqd_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cqd_pkg::dp_ctrl_t                 ctl,
    output cqd_pkg::dp_status_t               stat,
    input  logic signed [cqd_pkg::DATA_W-1:0] s_push_value,
    output logic [1:0]                        m_status,
    output logic signed [cqd_pkg::DATA_W-1:0] m_data_out,
    output logic                              m_last
);
    import cqd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [PTR_W-1:0] walk_reg, walk_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [PTR_W-1:0] walk_inc;
    logic [PTR_W-1:0] rd_addr;
    logic [1:0]               status_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic                     last_reg;

    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    assign walk_inc = slot_inc(walk_reg);

    assign stat.full      = (occ_reg == FULL_CNT);
    assign stat.empty     = (occ_reg == '0);
    assign stat.walk_last = (remain_reg == ONE_CNT);

    // Read address follows the walk; looks ahead when an entry is consumed
    always_comb begin
        priority if (ctl.walk_start) begin
            rd_addr = head_reg;
        end else if (ctl.walk_step) begin
            rd_addr = walk_inc;
        end else begin
            rd_addr = walk_reg;
        end
    end

    // Pointer and count updates
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        walk_next   = walk_reg;
        remain_next = remain_reg;
        if (ctl.wr_en) begin
            tail_next = slot_inc(tail_reg);
            occ_next  = occ_reg + ONE_CNT;
        end
        if (ctl.pop) begin
            head_next = slot_inc(head_reg);
            occ_next  = occ_reg - ONE_CNT;
        end
        if (ctl.walk_start) begin
            walk_next   = head_reg;
            remain_next = ctl.walk_one ? ONE_CNT : occ_reg;
        end else if (ctl.walk_step) begin
            walk_next   = walk_inc;
            remain_next = remain_reg - ONE_CNT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            occ_reg    <= '0;
            walk_reg   <= '0;
            remain_reg <= '0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            occ_reg    <= occ_next;
            walk_reg   <= walk_next;
            remain_reg <= remain_next;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[tail_reg] <= s_push_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Output payload registers
    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            status_reg <= ctl.out_status;
            data_reg   <= ctl.out_from_mem ? rd_data_reg : '0;
            last_reg   <= ctl.out_last;
        end
    end

    assign m_status   = status_reg;
    assign m_data_out = data_reg;
    assign m_last     = last_reg;

    // Count never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= FULL_CNT)
        else $error("cqd_dpath: occupancy above depth");

    // A write into a non-full queue raises the count by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.wr_en && !ctl.pop) |=> occ_reg == $past(occ_reg) + ONE_CNT)
        else $error("cqd_dpath: enqueue count mismatch");

    // A pop never happens on an empty queue and lowers the count by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.pop && !ctl.wr_en) |-> (!stat.empty ##1 occ_reg == $past(occ_reg) - ONE_CNT))
        else $error("cqd_dpath: dequeue count mismatch");

endmodule

/* design/circular_queue_with_dump.sv */
// ----------------------------------------------------------------------------
// circular_queue_with_dump: circular FIFO of signed words with a dump command
// Commands enqueue, dequeue, or list every stored word from head to tail.
//
//   Channel  Direction  Ports                                   Beat
//   s_       in         s_valid s_ready s_cmd s_push_value      one command
//   m_       out        m_valid m_ready m_status m_data_out m_last  one result
//
// Enqueue and every error/empty result: beat is valid in the cycle after accept.
// Dequeue: registered memory read, then the output payload register.
// Display of N entries: first beat as for dequeue, then one per cycle
// while m_ready stays high.
// A new command is taken once the previous one has loaded its last beat and
// the output register is empty or draining; m_ready low stalls the walk.
// Synchronous active-low reset clears pointers and count; entries need none.
// ----------------------------------------------------------------------------
module circular_queue_with_dump #(
    parameter int DEPTH = cqd_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_cmd,
    input  logic signed [cqd_pkg::DATA_W-1:0] s_push_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic signed [cqd_pkg::DATA_W-1:0] m_data_out,
    output logic                              m_last
);
    import cqd_pkg::*;

    dp_ctrl_t   ctl;
    dp_status_t stat;

    // Command sequencer
    cqd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // Storage, pointers and output payload
    cqd_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .stat         (stat),
        .s_push_value (s_push_value),
        .m_status     (m_status),
        .m_data_out   (m_data_out),
        .m_last       (m_last)
    );

endmodule
